@@ rtl/qfrv_pkg.sv @@
`timescale 1ns / 1ps

package qfrv_pkg;

    // Fixed field widths and formats.
    localparam int IN_W     = 32;
    localparam int OUT_W    = 32;
    localparam int SUM_W    = 64;
    localparam int LEN_W    = 32;
    localparam int RATIO_W  = 31;
    localparam int Q_FRAC   = 30;
    localparam int LEN_FRAC = 28;
    localparam int ROM_FRAC = 62;
    localparam int N_LANES  = 3;
    localparam logic [OUT_W-1:0] Q30_ONE = 32'h4000_0000;

    // Unsigned 64-bit quotient by shift and subtract, for elaboration-time tables.
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] q;
        logic [64:0] r;
        int          j;
        q = '0;
        r = '0;
        for (j = 63; j >= 0; j--) begin
            r = {r[63:0], num[j]};
            if (r >= {1'b0, den}) begin
                r    = r - {1'b0, den};
                q[j] = 1'b1;
            end
        end
        return q;
    endfunction

    // Unsigned rescale between fraction widths, rounding half up.
    function automatic logic [63:0] rescale_u(input logic [63:0] v, input int from_b,
                                              input int to_b);
        logic [63:0] r;
        if (to_b >= from_b) begin
            r = v << (to_b - from_b);
        end else begin
            r = (v + (64'd1 << (from_b - to_b - 1))) >> (from_b - to_b);
        end
        return r;
    endfunction

    // Arctangent of 1/n at 62 fraction bits by the integer power series.
    function automatic longint atan_inv_q62(input int n);
        logic [63:0] p;
        logic [63:0] n2;
        longint      s;
        int          k;
        p  = udiv64(64'd1 << 62, 64'(n));
        n2 = 64'(n) * 64'(n);
        s  = 0;
        for (k = 0; k < 40; k++) begin
            if (p != 64'd0) begin
                if ((k & 1) != 0) begin
                    s = s - longint'(udiv64(p, 64'(2 * k + 1)));
                end else begin
                    s = s + longint'(udiv64(p, 64'(2 * k + 1)));
                end
                p = udiv64(p, n2);
            end
        end
        return s;
    endfunction

    // Arctangent of 2^-i at 62 fraction bits, i of one or more.
    function automatic longint atan_pow2_q62(input int i);
        logic [63:0] p;
        longint      s;
        int          k;
        p = 64'd1 << (62 - i);
        s = 0;
        for (k = 0; k < 64; k++) begin
            if (p != 64'd0) begin
                if ((k & 1) != 0) begin
                    s = s - longint'(udiv64(p, 64'(2 * k + 1)));
                end else begin
                    s = s + longint'(udiv64(p, 64'(2 * k + 1)));
                end
                p = (2 * i >= 64) ? 64'd0 : (p >> (2 * i));
            end
        end
        return s;
    endfunction

    // Machin formula for pi/4 at 62 fraction bits.
    function automatic longint quarter_pi_q62();
        longint a5;
        longint a239;
        a5   = atan_inv_q62(5);
        a239 = atan_inv_q62(239);
        return 4 * a5 - a239;
    endfunction

    // Floor square root of a 64-bit value.
    function automatic logic [63:0] isqrt64(input logic [63:0] n);
        logic [63:0] res;
        logic [63:0] bitv;
        logic [63:0] rem;
        int          j;
        res  = 64'd0;
        bitv = 64'd1 << 62;
        rem  = n;
        for (j = 0; j < 32; j++) begin
            if (bitv > rem) begin
                bitv = bitv >> 2;
            end
        end
        for (j = 0; j < 32; j++) begin
            if (bitv != 64'd0) begin
                if (rem >= res + bitv) begin
                    rem = rem - (res + bitv);
                    res = (res >> 1) + bitv;
                end else begin
                    res = res >> 1;
                end
                bitv = bitv >> 2;
            end
        end
        return res;
    endfunction

    // Rotation angle of step i at f fraction bits.
    function automatic logic [63:0] atan_rom_f(input int i, input int f);
        longint a;
        a = (i == 0) ? quarter_pi_q62() : atan_pow2_q62(i);
        return rescale_u(64'(a), ROM_FRAC, f);
    endfunction

    // Quarter turn at f fraction bits.
    function automatic logic [63:0] half_pi_f(input int f);
        longint qp;
        qp = quarter_pi_q62();
        return rescale_u(64'(2 * qp), ROM_FRAC, f);
    endfunction

    // Inverse CORDIC gain at f fraction bits for a given number of steps.
    function automatic logic [63:0] gain_f(input int f, input int steps);
        logic [63:0] k2;
        int          i;
        k2 = 64'd1 << 62;
        for (i = 0; i < 64; i++) begin
            if (i < steps && 2 * i <= 62) begin
                k2 = k2 - udiv64(k2, (64'd1 << (2 * i)) + 64'd1);
            end
        end
        return rescale_u(isqrt64(k2), 31, f);
    endfunction

endpackage

@@ rtl/qfrv_sqrt.sv @@
`timescale 1ns / 1ps

module qfrv_sqrt #(
    parameter int SIDE_W = 1
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic [qfrv_pkg::SUM_W-1:0]    i_radicand,
    input  logic [SIDE_W-1:0]             i_side,
    output logic                          o_valid,
    output logic [qfrv_pkg::LEN_W-1:0]    o_root,
    output logic [SIDE_W-1:0]             o_side
);

    localparam int STEPS = qfrv_pkg::LEN_W;
    localparam int REM_W = qfrv_pkg::SUM_W + 2;

    logic [REM_W-1:0]            r_rem  [STEPS];
    logic [qfrv_pkg::LEN_W-1:0]  r_root [STEPS];
    logic [SIDE_W-1:0]           r_side [STEPS];
    logic                        r_vld  [STEPS];

    // One root bit per stage, most significant first.
    for (genvar g = 0; g < STEPS; g++) begin : g_stage
        localparam int B = STEPS - 1 - g;
        logic [REM_W-1:0]           p_rem;
        logic [qfrv_pkg::LEN_W-1:0] p_root;
        logic [SIDE_W-1:0]          p_side;
        logic                       p_vld;
        logic [REM_W-1:0]           trial;
        logic [REM_W-1:0]           n_rem;
        logic [qfrv_pkg::LEN_W-1:0] n_root;

        if (g == 0) begin : g_first
            assign p_rem  = REM_W'(i_radicand);
            assign p_root = '0;
            assign p_side = i_side;
            assign p_vld  = i_valid;
        end else begin : g_next
            assign p_rem  = r_rem[g-1];
            assign p_root = r_root[g-1];
            assign p_side = r_side[g-1];
            assign p_vld  = r_vld[g-1];
        end

        // Growth of the square when this bit is set.
        assign trial = (REM_W'(p_root) << (B + 1)) + (REM_W'(1) << (2 * B));

        always_comb begin
            n_rem  = p_rem;
            n_root = p_root;
            if (p_rem >= trial) begin
                n_rem     = p_rem - trial;
                n_root[B] = 1'b1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g] <= 1'b0;
            end else begin
                r_vld[g] <= p_vld;
            end
            r_rem[g]  <= n_rem;
            r_root[g] <= n_root;
            r_side[g] <= p_side;
        end
    end

    assign o_valid = r_vld[STEPS-1];
    assign o_root  = r_root[STEPS-1];
    assign o_side  = r_side[STEPS-1];

endmodule

@@ rtl/qfrv_div.sv @@
`timescale 1ns / 1ps

module qfrv_div #(
    parameter int SIDE_W = 1
) (
    input  logic                                                 i_clk,
    input  logic                                                 i_rst_n,
    input  logic                                                 i_valid,
    input  logic [qfrv_pkg::LEN_W-1:0]                           i_divisor,
    input  logic [qfrv_pkg::N_LANES-1:0][qfrv_pkg::IN_W-1:0]     i_mag,
    input  logic [SIDE_W-1:0]                                    i_side,
    output logic                                                 o_valid,
    output logic [qfrv_pkg::N_LANES-1:0][qfrv_pkg::RATIO_W-1:0]  o_quot,
    output logic [SIDE_W-1:0]                                    o_side
);

    localparam int STEPS = qfrv_pkg::RATIO_W;
    localparam int NL    = qfrv_pkg::N_LANES;
    localparam int REM_W = qfrv_pkg::IN_W + qfrv_pkg::Q_FRAC + 1;

    logic [NL-1:0][REM_W-1:0]             r_rem  [STEPS];
    logic [NL-1:0][qfrv_pkg::RATIO_W-1:0] r_quot [STEPS];
    logic [qfrv_pkg::LEN_W-1:0]           r_div  [STEPS];
    logic [SIDE_W-1:0]                    r_side [STEPS];
    logic                                 r_vld  [STEPS];

    // Restoring division, one quotient bit per stage in all three lanes.
    for (genvar g = 0; g < STEPS; g++) begin : g_stage
        localparam int B = STEPS - 1 - g;
        logic [NL-1:0][REM_W-1:0]             p_rem;
        logic [NL-1:0][qfrv_pkg::RATIO_W-1:0] p_quot;
        logic [qfrv_pkg::LEN_W-1:0]           p_div;
        logic [SIDE_W-1:0]                    p_side;
        logic                                 p_vld;
        logic [REM_W-1:0]                     dvs;
        logic [NL-1:0][REM_W-1:0]             n_rem;
        logic [NL-1:0][qfrv_pkg::RATIO_W-1:0] n_quot;

        if (g == 0) begin : g_first
            // Dividend is the magnitude at 30 fraction bits plus half the divisor.
            for (genvar l = 0; l < NL; l++) begin : g_lane
                assign p_rem[l] = (REM_W'(i_mag[l]) << qfrv_pkg::Q_FRAC)
                                + REM_W'(i_divisor >> 1);
            end
            assign p_quot = '0;
            assign p_div  = i_divisor;
            assign p_side = i_side;
            assign p_vld  = i_valid;
        end else begin : g_next
            assign p_rem  = r_rem[g-1];
            assign p_quot = r_quot[g-1];
            assign p_div  = r_div[g-1];
            assign p_side = r_side[g-1];
            assign p_vld  = r_vld[g-1];
        end

        assign dvs = REM_W'(p_div) << B;

        always_comb begin
            n_rem  = p_rem;
            n_quot = p_quot;
            for (int l = 0; l < NL; l++) begin
                if (p_rem[l] >= dvs) begin
                    n_rem[l]     = p_rem[l] - dvs;
                    n_quot[l][B] = 1'b1;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g] <= 1'b0;
            end else begin
                r_vld[g] <= p_vld;
            end
            r_rem[g]  <= n_rem;
            r_quot[g] <= n_quot;
            r_div[g]  <= p_div;
            r_side[g] <= p_side;
        end
    end

    assign o_valid = r_vld[STEPS-1];
    assign o_quot  = r_quot[STEPS-1];
    assign o_side  = r_side[STEPS-1];

endmodule

@@ rtl/qfrv_cordic.sv @@
`timescale 1ns / 1ps

module qfrv_cordic #(
    parameter int DATA_WIDTH   = 32,
    parameter int CORDIC_STEPS = 24,
    parameter int SIDE_W       = 1
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  logic signed [DATA_WIDTH+1:0] i_z,
    input  logic [SIDE_W-1:0]            i_side,
    output logic                         o_valid,
    output logic signed [DATA_WIDTH+1:0] o_x,
    output logic signed [DATA_WIDTH+1:0] o_y,
    output logic [SIDE_W-1:0]            o_side
);

    localparam int F  = DATA_WIDTH - 2;
    localparam int CW = DATA_WIDTH + 2;
    localparam logic [63:0] GAIN64 = qfrv_pkg::gain_f(F, CORDIC_STEPS);
    localparam logic signed [CW-1:0] GAIN = $signed(GAIN64[CW-1:0]);

    logic signed [CW-1:0] r_x    [CORDIC_STEPS];
    logic signed [CW-1:0] r_y    [CORDIC_STEPS];
    logic signed [CW-1:0] r_z    [CORDIC_STEPS];
    logic [SIDE_W-1:0]    r_side [CORDIC_STEPS];
    logic                 r_vld  [CORDIC_STEPS];

    // One micro-rotation per stage; direction from the sign of the residual angle.
    for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_stage
        localparam logic [63:0] ANG64 = qfrv_pkg::atan_rom_f(g, F);
        localparam logic signed [CW-1:0] ANG = $signed(ANG64[CW-1:0]);
        logic signed [CW-1:0] p_x;
        logic signed [CW-1:0] p_y;
        logic signed [CW-1:0] p_z;
        logic [SIDE_W-1:0]    p_side;
        logic                 p_vld;
        logic signed [CW-1:0] dx;
        logic signed [CW-1:0] dy;
        logic signed [CW-1:0] n_x;
        logic signed [CW-1:0] n_y;
        logic signed [CW-1:0] n_z;

        if (g == 0) begin : g_first
            assign p_x    = GAIN;
            assign p_y    = '0;
            assign p_z    = i_z;
            assign p_side = i_side;
            assign p_vld  = i_valid;
        end else begin : g_next
            assign p_x    = r_x[g-1];
            assign p_y    = r_y[g-1];
            assign p_z    = r_z[g-1];
            assign p_side = r_side[g-1];
            assign p_vld  = r_vld[g-1];
        end

        assign dx = p_y >>> g;
        assign dy = p_x >>> g;

        always_comb begin
            if (!p_z[CW-1]) begin
                n_x = p_x - dx;
                n_y = p_y + dy;
                n_z = p_z - ANG;
            end else begin
                n_x = p_x + dx;
                n_y = p_y - dy;
                n_z = p_z + ANG;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g] <= 1'b0;
            end else begin
                r_vld[g] <= p_vld;
            end
            r_x[g]    <= n_x;
            r_y[g]    <= n_y;
            r_z[g]    <= n_z;
            r_side[g] <= p_side;
        end
    end

    assign o_valid = r_vld[CORDIC_STEPS-1];
    assign o_x     = r_x[CORDIC_STEPS-1];
    assign o_y     = r_y[CORDIC_STEPS-1];
    assign o_side  = r_side[CORDIC_STEPS-1];

endmodule

@@ rtl/quaternion_from_rotation_vector_unit.sv @@
`timescale 1ns / 1ps

// Rotation vector (Q3.28 radians) to unit quaternion (Q1.30). The unit is a fixed-latency
// pipeline that takes one request per clock while busy is low (busy is high only in reset
// and the first cycle after it). Each result appears on the o_quat_* ports for one cycle
// with o_strobe high; the receiver must capture it then. Its stages include the 32-stage
// square root, the 31-stage divider for the axis components and one stage per CORDIC step.
// A zero vector gives the identity quaternion.
module quaternion_from_rotation_vector_unit #(
    parameter int DATA_WIDTH   = 32,
    parameter int CORDIC_STEPS = 24
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [qfrv_pkg::IN_W-1:0]    i_rot_x,
    input  logic signed [qfrv_pkg::IN_W-1:0]    i_rot_y,
    input  logic signed [qfrv_pkg::IN_W-1:0]    i_rot_z,
    output logic                                o_strobe,
    output logic signed [qfrv_pkg::OUT_W-1:0]   o_quat_w,
    output logic signed [qfrv_pkg::OUT_W-1:0]   o_quat_x,
    output logic signed [qfrv_pkg::OUT_W-1:0]   o_quat_y,
    output logic signed [qfrv_pkg::OUT_W-1:0]   o_quat_z
);

    localparam int F       = DATA_WIDTH - 2;
    localparam int CW      = DATA_WIDTH + 2;
    localparam int HW      = CW;
    localparam int RW      = CW + 31;
    localparam int NL      = qfrv_pkg::N_LANES;
    localparam int IW      = qfrv_pkg::IN_W;
    localparam int QW      = qfrv_pkg::RATIO_W;
    localparam int LATENCY = 74 + CORDIC_STEPS;

    localparam logic [63:0] P64 = qfrv_pkg::half_pi_f(F);
    localparam logic [HW:0] H2  = (HW + 1)'(P64 >> 1);
    localparam logic [HW:0] KP1 = (HW + 1)'(P64);
    localparam logic [HW:0] KP2 = (HW + 1)'(2 * P64);
    localparam logic [HW:0] KP3 = (HW + 1)'(3 * P64);
    localparam logic [HW:0] KP4 = (HW + 1)'(4 * P64);
    localparam logic [RW-1:0] CLAMP = RW'(qfrv_pkg::Q30_ONE);

    typedef struct packed {
        logic [NL-1:0][IW-1:0] mag;
        logic [NL-1:0]         neg;
        logic                  zero;
    } t_sq_side;

    typedef struct packed {
        logic [NL-1:0]                  neg;
        logic                           zero;
        logic [qfrv_pkg::LEN_W-1:0]     len;
    } t_div_side;

    typedef struct packed {
        logic [NL-1:0][QW-1:0] ratio;
        logic [NL-1:0]         neg;
        logic                  zero;
        logic [1:0]            quad;
    } t_rot_side;

    // Ready comes up in the cycle after reset is released.
    logic r_ready;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ready <= 1'b0;
        end else begin
            r_ready <= 1'b1;
        end
    end
    assign busy = ~r_ready;

    // Input register.
    logic                  r0_vld;
    logic [NL-1:0][IW-1:0] r0_rot;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_vld <= 1'b0;
        end else begin
            r0_vld <= start & ~busy;
        end
        r0_rot <= {i_rot_z, i_rot_y, i_rot_x};
    end

    // Component magnitudes and signs.
    logic                  r1_vld;
    logic [NL-1:0][IW-1:0] r1_mag;
    logic [NL-1:0]         r1_neg;
    logic                  r1_zero;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else begin
            r1_vld <= r0_vld;
        end
        for (int l = 0; l < NL; l++) begin
            r1_neg[l] <= r0_rot[l][IW-1];
            r1_mag[l] <= r0_rot[l][IW-1] ? (~r0_rot[l] + IW'(1)) : r0_rot[l];
        end
        r1_zero <= (r0_rot == '0);
    end

    // Squares.
    logic                                 r2_vld;
    logic [NL-1:0][qfrv_pkg::SUM_W-1:0]   r2_sq;
    t_sq_side                             r2_side;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else begin
            r2_vld <= r1_vld;
        end
        for (int l = 0; l < NL; l++) begin
            r2_sq[l] <= qfrv_pkg::SUM_W'(r1_mag[l]) * qfrv_pkg::SUM_W'(r1_mag[l]);
        end
        r2_side.mag  <= r1_mag;
        r2_side.neg  <= r1_neg;
        r2_side.zero <= r1_zero;
    end

    // Sum of squares, exact in 64 bits.
    logic                         r3_vld;
    logic [qfrv_pkg::SUM_W-1:0]   r3_sum;
    t_sq_side                     r3_side;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else begin
            r3_vld <= r2_vld;
        end
        r3_sum  <= r2_sq[0] + r2_sq[1] + r2_sq[2];
        r3_side <= r2_side;
    end

    // Length of the vector.
    logic                         sq_vld;
    logic [qfrv_pkg::LEN_W-1:0]   sq_len;
    t_sq_side                     sq_side;
    qfrv_sqrt #(
        .SIDE_W ($bits(t_sq_side))
    ) u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (r3_vld),
        .i_radicand (r3_sum),
        .i_side     (r3_side),
        .o_valid    (sq_vld),
        .o_root     (sq_len),
        .o_side     (sq_side)
    );

    // Unit axis components, r_j * 2^30 / length.
    t_div_side             dv_in;
    t_div_side             dv_side;
    logic                  dv_vld;
    logic [NL-1:0][QW-1:0] dv_quot;
    assign dv_in.neg  = sq_side.neg;
    assign dv_in.zero = sq_side.zero;
    assign dv_in.len  = sq_len;
    qfrv_div #(
        .SIDE_W ($bits(t_div_side))
    ) u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (sq_vld),
        .i_divisor (sq_len),
        .i_mag     (sq_side.mag),
        .i_side    (dv_in),
        .o_valid   (dv_vld),
        .o_quot    (dv_quot),
        .o_side    (dv_side)
    );

    // Half angle at F fraction bits, rounded half up.
    logic [HW-1:0] n_h;
    if (F >= qfrv_pkg::LEN_FRAC + 1) begin : g_h_up
        assign n_h = HW'(dv_side.len) << (F - qfrv_pkg::LEN_FRAC - 1);
    end else begin : g_h_down
        logic [qfrv_pkg::LEN_W:0] h_sum;
        assign h_sum = (qfrv_pkg::LEN_W + 1)'(dv_side.len)
                     + ((qfrv_pkg::LEN_W + 1)'(1) << (qfrv_pkg::LEN_FRAC - F));
        assign n_h   = HW'(h_sum >> (qfrv_pkg::LEN_FRAC + 1 - F));
    end

    logic                  r4_vld;
    logic [HW-1:0]         r4_h;
    t_rot_side             r4_side;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_vld <= 1'b0;
        end else begin
            r4_vld <= dv_vld;
        end
        r4_h          <= n_h;
        r4_side.ratio <= dv_quot;
        r4_side.neg   <= dv_side.neg;
        r4_side.zero  <= dv_side.zero;
        r4_side.quad  <= '0;
    end

    // Nearest quarter turn, k = floor((h + P/2) / P), k at most four.
    logic [HW:0] hp;
    logic [2:0]  n_kq;
    assign hp = (HW + 1)'(r4_h) + H2;
    always_comb begin
        if (hp >= KP4) begin
            n_kq = 3'd4;
        end else if (hp >= KP3) begin
            n_kq = 3'd3;
        end else if (hp >= KP2) begin
            n_kq = 3'd2;
        end else if (hp >= KP1) begin
            n_kq = 3'd1;
        end else begin
            n_kq = 3'd0;
        end
    end

    logic          r5_vld;
    logic [HW-1:0] r5_h;
    logic [2:0]    r5_kq;
    t_rot_side     r5_side;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_vld <= 1'b0;
        end else begin
            r5_vld <= r4_vld;
        end
        r5_h    <= r4_h;
        r5_kq   <= n_kq;
        r5_side <= r4_side;
    end

    // Residual angle after removing the quarter turns.
    logic [HW:0]        kp_sel;
    logic signed [HW:0] n_rr;
    always_comb begin
        case (r5_kq)
            3'd1:    kp_sel = KP1;
            3'd2:    kp_sel = KP2;
            3'd3:    kp_sel = KP3;
            3'd4:    kp_sel = KP4;
            default: kp_sel = '0;
        endcase
    end
    assign n_rr = $signed({1'b0, r5_h}) - $signed(kp_sel);

    logic                 r6_vld;
    logic signed [CW-1:0] r6_rr;
    t_rot_side            r6_side;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_vld <= 1'b0;
        end else begin
            r6_vld <= r5_vld;
        end
        r6_rr         <= $signed(n_rr[CW-1:0]);
        r6_side.ratio <= r5_side.ratio;
        r6_side.neg   <= r5_side.neg;
        r6_side.zero  <= r5_side.zero;
        r6_side.quad  <= r5_kq[1:0];
    end

    // Cosine and sine of the residual.
    logic                 co_vld;
    logic signed [CW-1:0] co_x;
    logic signed [CW-1:0] co_y;
    t_rot_side            co_side;
    qfrv_cordic #(
        .DATA_WIDTH   (DATA_WIDTH),
        .CORDIC_STEPS (CORDIC_STEPS),
        .SIDE_W       ($bits(t_rot_side))
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r6_vld),
        .i_z     (r6_rr),
        .i_side  (r6_side),
        .o_valid (co_vld),
        .o_x     (co_x),
        .o_y     (co_y),
        .o_side  (co_side)
    );

    // Apply the quarter turns exactly.
    logic                 r7_vld;
    logic signed [CW-1:0] r7_c;
    logic signed [CW-1:0] r7_s;
    t_rot_side            r7_side;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r7_vld <= 1'b0;
        end else begin
            r7_vld <= co_vld;
        end
        case (co_side.quad)
            2'd0: begin
                r7_c <= co_x;
                r7_s <= co_y;
            end
            2'd1: begin
                r7_c <= -co_y;
                r7_s <= co_x;
            end
            2'd2: begin
                r7_c <= -co_x;
                r7_s <= -co_y;
            end
            default: begin
                r7_c <= co_y;
                r7_s <= -co_x;
            end
        endcase
        r7_side <= co_side;
    end

    // Rescale to 30 fraction bits on magnitudes, round half away from zero, clamp to one.
    logic [CW-1:0]  c_mag;
    logic [CW-1:0]  s_mag;
    logic [RW-1:0]  c_sc;
    logic [RW-1:0]  s_sc;
    logic [QW-1:0]  c_q30;
    logic [QW-1:0]  s_q30;
    assign c_mag = r7_c[CW-1] ? CW'(-r7_c) : CW'(r7_c);
    assign s_mag = r7_s[CW-1] ? CW'(-r7_s) : CW'(r7_s);
    if (F > qfrv_pkg::Q_FRAC) begin : g_rs_down
        assign c_sc = (RW'(c_mag) + (RW'(1) << (F - qfrv_pkg::Q_FRAC - 1)))
                    >> (F - qfrv_pkg::Q_FRAC);
        assign s_sc = (RW'(s_mag) + (RW'(1) << (F - qfrv_pkg::Q_FRAC - 1)))
                    >> (F - qfrv_pkg::Q_FRAC);
    end else begin : g_rs_up
        assign c_sc = RW'(c_mag) << (qfrv_pkg::Q_FRAC - F);
        assign s_sc = RW'(s_mag) << (qfrv_pkg::Q_FRAC - F);
    end
    assign c_q30 = (c_sc > CLAMP) ? QW'(CLAMP) : c_sc[QW-1:0];
    assign s_q30 = (s_sc > CLAMP) ? QW'(CLAMP) : s_sc[QW-1:0];

    logic          r8_vld;
    logic [QW-1:0] r8_c_mag;
    logic          r8_c_neg;
    logic [QW-1:0] r8_s_mag;
    logic          r8_s_neg;
    t_rot_side     r8_side;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r8_vld <= 1'b0;
        end else begin
            r8_vld <= r7_vld;
        end
        r8_c_mag <= c_q30;
        r8_c_neg <= r7_c[CW-1];
        r8_s_mag <= s_q30;
        r8_s_neg <= r7_s[CW-1] && (s_q30 != '0);
        r8_side  <= r7_side;
    end

    // Axis component times sine.
    logic                             r9_vld;
    logic [NL-1:0][2*QW-1:0]          r9_prod;
    logic [NL-1:0]                    r9_neg;
    logic signed [qfrv_pkg::OUT_W-1:0] r9_w;
    logic                             r9_zero;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r9_vld <= 1'b0;
        end else begin
            r9_vld <= r8_vld;
        end
        for (int l = 0; l < NL; l++) begin
            r9_prod[l] <= (2 * QW)'(r8_side.ratio[l]) * (2 * QW)'(r8_s_mag);
            r9_neg[l]  <= r8_side.neg[l] ^ r8_s_neg;
        end
        r9_w    <= r8_c_neg ? -$signed(qfrv_pkg::OUT_W'(r8_c_mag))
                            : $signed(qfrv_pkg::OUT_W'(r8_c_mag));
        r9_zero <= r8_side.zero;
    end

    // Round the products, apply signs, and substitute the identity for a zero vector.
    logic [NL-1:0][qfrv_pkg::OUT_W-1:0] q_mag;
    logic [NL-1:0][qfrv_pkg::OUT_W-1:0] q_val;
    always_comb begin
        for (int l = 0; l < NL; l++) begin
            q_mag[l] = qfrv_pkg::OUT_W'((r9_prod[l] + ((2 * QW)'(1) << (qfrv_pkg::Q_FRAC - 1)))
                                        >> qfrv_pkg::Q_FRAC);
            q_val[l] = r9_neg[l] ? (~q_mag[l] + qfrv_pkg::OUT_W'(1)) : q_mag[l];
        end
    end

    logic                               r10_vld;
    logic [qfrv_pkg::OUT_W-1:0]         r10_w;
    logic [NL-1:0][qfrv_pkg::OUT_W-1:0] r10_q;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r10_vld <= 1'b0;
        end else begin
            r10_vld <= r9_vld;
        end
        if (r9_zero) begin
            r10_w <= qfrv_pkg::Q30_ONE;
            r10_q <= '0;
        end else begin
            r10_w <= r9_w;
            r10_q <= q_val;
        end
    end

    assign o_strobe = r10_vld;
    assign o_quat_w = $signed(r10_w);
    assign o_quat_x = $signed(r10_q[0]);
    assign o_quat_y = $signed(r10_q[1]);
    assign o_quat_z = $signed(r10_q[2]);

    // Every request yields a result after the fixed latency.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LATENCY o_strobe)
        else $error("request did not produce a result at the pipeline latency");

    // No result without a request the fixed latency earlier.
    a_no_extra: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(start && !busy, LATENCY))
        else $error("result without a matching request");

    // The scalar part stays within the unit range.
    a_w_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> ($signed(o_quat_w) <= $signed(qfrv_pkg::Q30_ONE)
                  && $signed(o_quat_w) >= -$signed(qfrv_pkg::Q30_ONE)))
        else $error("quat_w out of range");

    // The vector part stays within the unit range.
    a_xyz_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> ($signed(o_quat_x) <= $signed(qfrv_pkg::Q30_ONE)
                  && $signed(o_quat_x) >= -$signed(qfrv_pkg::Q30_ONE)
                  && $signed(o_quat_y) <= $signed(qfrv_pkg::Q30_ONE)
                  && $signed(o_quat_y) >= -$signed(qfrv_pkg::Q30_ONE)
                  && $signed(o_quat_z) <= $signed(qfrv_pkg::Q30_ONE)
                  && $signed(o_quat_z) >= -$signed(qfrv_pkg::Q30_ONE)))
        else $error("vector part out of range");

endmodule
